// File: src/tfc_pkg.sv
// package for the thermal fan curve controller
// holds cause codes, register indexes, constants, the state codes and the lane status struct
`default_nettype none
package tfc_pkg;

  localparam int unsigned Sensors = 4;
  localparam int unsigned NumCfg = 8;

  typedef enum logic [1:0] {
    CAUSE_CURVE  = 2'd0,
    CAUSE_FAN    = 2'd1,
    CAUSE_SUPPLY = 2'd2,
    CAUSE_START  = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    REG_CPU_MIN   = 3'd0,
    REG_CPU_MAX   = 3'd1,
    REG_BOARD_MIN = 3'd2,
    REG_BOARD_MAX = 3'd3,
    REG_HOT_MIN   = 3'd4,
    REG_HOT_MAX   = 3'd5,
    REG_FLOOR     = 3'd6,
    REG_CEILING   = 3'd7
  } reg_e;

  localparam logic [7:0] PwmStart = 8'd128;
  localparam logic [7:0] PwmMax = 8'd255;
  localparam logic [15:0] PwmFaultDef = 16'd1000;

  // lane control and status
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

endpackage
`default_nettype wire

// File: src/tfc_div.sv
// sequential signed divider, one quotient bit per cycle, truncating toward zero
// depends on tfc_pkg for the control struct
`default_nettype none
module tfc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [17:0] num_i,
  input  wire logic        [8:0]  den_i,
  output tfc_pkg::lane_ctl_t      ctl_o,
  output logic signed [18:0]      quo_o
);
  logic [17:0] rem_q, rem_d, quo_q, quo_d;
  logic [8:0]  den_q, den_d;
  logic        neg_q, neg_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [18:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[17]} - {10'd0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[17] ? 18'(-num_i) : 18'(num_i);
      neg_d  = num_i[17];
      den_d  = den_i;
      cnt_d  = 5'd18;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[18]) begin
        rem_d = trial[17:0];
        quo_d = {quo_q[16:0], 1'b1};
      end else begin
        rem_d = {rem_q[16:0], quo_q[17]};
        quo_d = {quo_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign quo_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
endmodule
`default_nettype wire

// File: src/tfc_lane.sv
// one sensor lane: curve products, two divisions, hysteresis and clamp
// depends on tfc_pkg and tfc_div
`default_nettype none
module tfc_lane #(
  parameter int unsigned Hyst = 3
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] temp_i,
  input  wire logic [7:0] prev_temp_i,
  input  wire logic [7:0] prev_duty_i,
  input  wire logic [7:0] tmin_i,
  input  wire logic [7:0] tmax_i,
  input  wire logic [7:0] floor_i,
  input  wire logic [7:0] ceil_i,
  output logic            done_o,
  output logic [7:0]      duty_o
);
  localparam logic signed [9:0] HystS = 10'(Hyst);
  logic signed [9:0]  span, dt, gain;
  logic signed [17:0] num_up_q, num_lo_q;
  logic               span_bad_q, phase_q;
  logic               div_start;
  logic signed [17:0] div_num;
  tfc_pkg::lane_ctl_t dctl;
  logic signed [18:0] quo;
  logic signed [18:0] up_q;
  logic signed [20:0] up_s, lo_s;
  logic [8:0]         up_c, lo_c, dv;
  logic               start_q, done_q;
  logic [7:0]         duty_q;

  assign span = $signed({2'b0, tmax_i}) - $signed({2'b0, tmin_i}) - HystS;
  assign dt   = $signed({2'b0, temp_i}) - $signed({2'b0, tmin_i});
  assign gain = $signed({2'b0, ceil_i}) - $signed({2'b0, floor_i});

  // operands widened before the multiply so the product keeps all its bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_up_q   <= 18'(dt) * 18'(gain);
      num_lo_q   <= 18'(dt - HystS) * 18'(gain);
      span_bad_q <= (span <= 0);
    end
  end

  assign div_start = start_q || (dctl.done && !phase_q);
  assign div_num   = start_q ? num_up_q : num_lo_q;

  tfc_div u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (div_num), .den_i (span[8:0]), .ctl_o (dctl), .quo_o (quo)
  );

  always_ff @(posedge clk_i) if (dctl.done && !phase_q) up_q <= quo;

  assign up_s = 21'(up_q) + 21'($signed({1'b0, floor_i}));
  assign lo_s = 21'(quo) + 21'($signed({1'b0, floor_i}));
  assign up_c = up_s < 0 ? 9'd0 : (up_s > 255 ? 9'd255 : up_s[8:0]);
  assign lo_c = lo_s < 0 ? 9'd0 : (lo_s > 255 ? 9'd255 : lo_s[8:0]);

  always_comb begin
    if (temp_i > prev_temp_i) dv = (lo_c < {1'b0, prev_duty_i}) ? {1'b0, prev_duty_i} : lo_c;
    else if (temp_i < prev_temp_i)
      dv = (up_c > {1'b0, prev_duty_i}) ? {1'b0, prev_duty_i} : up_c;
    else dv = {1'b0, prev_duty_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0; start_q <= 1'b0; done_q <= 1'b0;
    end else begin
      start_q <= start_i;
      done_q  <= dctl.done && phase_q;
      if (start_q) phase_q <= 1'b0;
      else if (dctl.done) phase_q <= ~phase_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dctl.done && phase_q) begin
      if (span_bad_q) duty_q <= ceil_i;
      else if (dv > {1'b0, ceil_i}) duty_q <= ceil_i;
      else if (dv < {1'b0, floor_i}) duty_q <= floor_i;
      else duty_q <= dv[7:0];
    end
  end

  assign done_o = done_q;
  assign duty_o = duty_q;
endmodule
`default_nettype wire

// File: src/thermal_fan_curve_controller.sv
// thermal fan curve controller top level
// depends on tfc_pkg and tfc_lane
// Each item is one poll tick. Fan or supply faults answer at once with full
// duty; otherwise four lanes, one per sensor, run their curves in parallel,
// each with one shared bit-serial divider doing two 18-step divisions, and a
// merge stage takes the largest duty. An item passes lane start, the operand
// register, the two serial divisions, the clamp and the merge before the
// output handshake; no new item is taken until its output has been accepted.
// The first item after reset also yields a start-up duty of 128 ahead of its
// regular result.
// Configuration may be written only while idle.
`default_nettype none
module thermal_fan_curve_controller #(
  parameter int unsigned HYSTERESIS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // temps 4x8 [31:0], fan rpm 3x16 [79:32], supply right [80], left [81], pad to 88
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // fan_duty [7:0]
  output logic [7:0]       m_axis_tdata,
  // cause [1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  localparam int unsigned S = tfc_pkg::Sensors;

  logic [7:0] cfg_q [tfc_pkg::NumCfg];
  logic [7:0] prev_temp_q [S];
  logic [7:0] prev_duty_q [S];
  logic       started_q;
  logic [7:0] temp_q [S];
  tfc_pkg::state_e state_q, state_d;
  logic       start_pend_q;
  logic [1:0] cause_q;
  logic [7:0] duty_q;
  logic       lane_go;
  logic [S-1:0] lane_done;
  logic [7:0] lane_duty [S];
  logic       acc, out_acc, fan_bad, sup_bad;
  logic [7:0] best01, best23, best;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == tfc_pkg::ST_IDLE);
  assign fan_bad = (s_axis_tdata[47:32] < tfc_pkg::PwmFaultDef) ||
                   (s_axis_tdata[63:48] < tfc_pkg::PwmFaultDef) ||
                   (s_axis_tdata[79:64] < tfc_pkg::PwmFaultDef);
  assign sup_bad = s_axis_tdata[80] || s_axis_tdata[81];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[tfc_pkg::REG_CPU_MIN]   <= 8'd67;
      cfg_q[tfc_pkg::REG_CPU_MAX]   <= 8'd85;
      cfg_q[tfc_pkg::REG_BOARD_MIN] <= 8'd32;
      cfg_q[tfc_pkg::REG_BOARD_MAX] <= 8'd48;
      cfg_q[tfc_pkg::REG_HOT_MIN]   <= 8'd52;
      cfg_q[tfc_pkg::REG_HOT_MAX]   <= 8'd70;
      cfg_q[tfc_pkg::REG_FLOOR]     <= 8'd102;
      cfg_q[tfc_pkg::REG_CEILING]   <= 8'd255;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // lane per sensor: cpu, board a, board b, hot
  for (genvar g = 0; g < S; g++) begin : g_lane
    localparam logic [2:0] MinIdx = (g == 0) ? tfc_pkg::REG_CPU_MIN :
                                    ((g == 3) ? tfc_pkg::REG_HOT_MIN : tfc_pkg::REG_BOARD_MIN);
    localparam logic [2:0] MaxIdx = (g == 0) ? tfc_pkg::REG_CPU_MAX :
                                    ((g == 3) ? tfc_pkg::REG_HOT_MAX : tfc_pkg::REG_BOARD_MAX);
    tfc_lane #(.Hyst(HYSTERESIS)) u_lane (
      .clk_i (clk_i), .rst_ni (rst_ni), .start_i (lane_go),
      .temp_i (temp_q[g]), .prev_temp_i (prev_temp_q[g]),
      .prev_duty_i (prev_duty_q[g]),
      .tmin_i (cfg_q[MinIdx]), .tmax_i (cfg_q[MaxIdx]),
      .floor_i (cfg_q[tfc_pkg::REG_FLOOR]), .ceil_i (cfg_q[tfc_pkg::REG_CEILING]),
      .done_o (lane_done[g]), .duty_o (lane_duty[g])
    );
  end

  // merge: largest of the four
  assign best01 = (lane_duty[1] > lane_duty[0]) ? lane_duty[1] : lane_duty[0];
  assign best23 = (lane_duty[3] > lane_duty[2]) ? lane_duty[3] : lane_duty[2];
  assign best   = (best23 > best01) ? best23 : best01;

  logic lane_go_q;
  assign lane_go = lane_go_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tfc_pkg::ST_IDLE: if (acc) state_d = (fan_bad || sup_bad) ? tfc_pkg::ST_OUT
                                                                : tfc_pkg::ST_RUN;
      tfc_pkg::ST_RUN:  if (lane_done[0]) state_d = tfc_pkg::ST_OUT;
      tfc_pkg::ST_OUT:  if (out_acc && !start_pend_q) state_d = tfc_pkg::ST_IDLE;
      default:          state_d = tfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfc_pkg::ST_IDLE;
      started_q <= 1'b0; start_pend_q <= 1'b0; lane_go_q <= 1'b0;
      for (int i = 0; i < S; i++) begin
        prev_temp_q[i] <= '0; prev_duty_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      lane_go_q <= acc && !fan_bad && !sup_bad;
      if (acc) begin
        start_pend_q <= !started_q;
        started_q <= 1'b1;
      end else if (out_acc && start_pend_q) begin
        start_pend_q <= 1'b0;
      end
      if (state_q == tfc_pkg::ST_RUN && lane_done[0]) begin
        for (int i = 0; i < S; i++) begin
          prev_temp_q[i] <= temp_q[i]; prev_duty_q[i] <= lane_duty[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int i = 0; i < S; i++) temp_q[i] <= s_axis_tdata[8*i +: 8];
      duty_q  <= tfc_pkg::PwmMax;
      cause_q <= fan_bad ? tfc_pkg::CAUSE_FAN : tfc_pkg::CAUSE_SUPPLY;
    end else if (state_q == tfc_pkg::ST_RUN && lane_done[0]) begin
      duty_q <= best; cause_q <= tfc_pkg::CAUSE_CURVE;
    end
  end

  // start-up item may go out while the lanes still run
  assign m_axis_tvalid = start_pend_q || (state_q == tfc_pkg::ST_OUT);
  assign m_axis_tdata  = start_pend_q ? tfc_pkg::PwmStart : duty_q;
  assign m_axis_tuser  = start_pend_q ? tfc_pkg::CAUSE_START : cause_q;
  assign m_axis_tlast  = !start_pend_q;

  a_lanes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> lane_done == {S{1'b1}}) else $error("lanes out of step");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tfc_pkg::ST_RUN |-> !s_axis_tready) else $error("accept while busy");
  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_pend_q |-> started_q) else $error("start-up item without start");
endmodule
`default_nettype wire
